// ===== src/cobsd_pkg.sv =====
// Shared types and constants for the COBS stream deframer.
// No dependencies; used by every module under src.
`timescale 1ns / 1ps
`default_nettype none

package cobsd_pkg;

  localparam int unsigned ByteW = 8;

  // Code byte that opens a full block; no zero follows such a block
  localparam logic [ByteW-1:0] CODE_FULL = 8'hFF;

  // Limit on encoded bytes per frame after reset
  localparam logic [ByteW-1:0] MAX_LEN_RST = 8'd252;

  // Frame end status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  typedef struct packed {
    logic [ByteW-1:0] decoded_byte;
    logic             byte_valid;
    logic             frame_end;
    logic [1:0]       frame_status;
  } res_t;

endpackage

`default_nettype wire

// ===== src/cobsd_core.sv =====
// Per-byte COBS decode: frame state registers and the next-state/result logic.
// Depends on cobsd_pkg for the result type and code constants.
`timescale 1ns / 1ps
`default_nettype none

module cobsd_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic [cobsd_pkg::ByteW-1:0] enc_byte,
  input  wire logic [cobsd_pkg::ByteW-1:0] max_len,
  output cobsd_pkg::res_t                  res,
  output logic                             res_vld
);

  logic [cobsd_pkg::ByteW-1:0] rem_r, rem_nxt;
  logic [cobsd_pkg::ByteW-1:0] cnt_r, cnt_nxt;
  logic                        full_r, full_nxt;
  logic                        seen_r, seen_nxt;
  logic                        ovf_r, ovf_nxt;

  always_comb begin
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    full_nxt = full_r;
    seen_nxt = seen_r;
    ovf_nxt  = ovf_r;
    res      = '0;
    res_vld  = 1'b0;
    if (enc_byte == '0) begin
      // Delimiter: close the frame, empty frames give nothing
      if (ovf_r) begin
        res.frame_end    = 1'b1;
        res.frame_status = cobsd_pkg::ST_OVF;
        res_vld          = 1'b1;
      end else if (cnt_r != '0) begin
        res.frame_end    = 1'b1;
        res.frame_status = (rem_r != '0) ? cobsd_pkg::ST_TRUNC : cobsd_pkg::ST_OK;
        res_vld          = 1'b1;
      end
      rem_nxt  = '0;
      cnt_nxt  = '0;
      full_nxt = 1'b0;
      seen_nxt = 1'b0;
      ovf_nxt  = 1'b0;
    end else if (!ovf_r) begin
      if (cnt_r >= max_len) begin
        ovf_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        if (rem_r != '0) begin
          rem_nxt          = rem_r - 1'b1;
          res.decoded_byte = enc_byte;
          res.byte_valid   = 1'b1;
          res_vld          = 1'b1;
        end else begin
          // Code byte: insert the implied zero after an earlier block unless that block was full
          rem_nxt  = enc_byte - 1'b1;
          full_nxt = (enc_byte == cobsd_pkg::CODE_FULL);
          seen_nxt = 1'b1;
          if (seen_r && !full_r) begin
            res.byte_valid = 1'b1;
            res_vld        = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      cnt_r  <= '0;
      full_r <= 1'b0;
      seen_r <= 1'b0;
      ovf_r  <= 1'b0;
    end else if (step) begin
      rem_r  <= rem_nxt;
      cnt_r  <= cnt_nxt;
      full_r <= full_nxt;
      seen_r <= seen_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/cobsd_out_reg.sv =====
// Result register with valid/ready towards the consumer.
// Depends on cobsd_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module cobsd_out_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire cobsd_pkg::res_t  load_data,
  output logic                  can_load,
  output logic                  out_vld,
  input  wire logic             out_rdy,
  output cobsd_pkg::res_t       out_data
);

  logic            vld_r, vld_nxt;
  cobsd_pkg::res_t data_r;

  assign can_load = !vld_r || out_rdy;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_rdy) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

`default_nettype wire

// ===== src/cobs_stream_deframer_unit.sv =====
// Pipeline: an accepted byte is held in the input register, decoded by the core
// logic and its result loaded into the result register, from which it is offered.
// Throughput: one byte per cycle, but a byte that makes a result waits while the
// result register is full and out_ready is low. Reset: synchronous on rst_n low;
// clears the frame state and both stages and loads the length limit with 252.
`timescale 1ns / 1ps
`default_nettype none

module cobs_stream_deframer_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [cobsd_pkg::ByteW-1:0] in_encoded_byte,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [cobsd_pkg::ByteW-1:0]      out_decoded_byte,
  output logic                             out_byte_valid,
  output logic                             out_frame_end,
  output logic [1:0]                       out_frame_status,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [cobsd_pkg::ByteW-1:0] cfg_data
);

  logic [cobsd_pkg::ByteW-1:0] max_len_r;
  logic                        in_vld_r;
  logic [cobsd_pkg::ByteW-1:0] in_byte_r;
  logic                        step;
  logic                        res_vld;
  logic                        can_load;
  cobsd_pkg::res_t             res;
  cobsd_pkg::res_t             out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= cobsd_pkg::MAX_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= cfg_data;
    end
  end

  // Advance the held byte when it makes no result or the result register is free
  assign step     = in_vld_r && (can_load || !res_vld);
  assign in_ready = !in_vld_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_encoded_byte;
    end
  end

  cobsd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .enc_byte (in_byte_r),
    .max_len  (max_len_r),
    .res      (res),
    .res_vld  (res_vld)
  );

  cobsd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res_vld),
    .load_data (res),
    .can_load  (can_load),
    .out_vld   (out_valid),
    .out_rdy   (out_ready),
    .out_data  (out_data)
  );

  assign out_decoded_byte = out_data.decoded_byte;
  assign out_byte_valid   = out_data.byte_valid;
  assign out_frame_end    = out_data.frame_end;
  assign out_frame_status = out_data.frame_status;

  a_end_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> !out_byte_valid && out_decoded_byte == '0)
    else $error("frame end result carries data");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_status == cobsd_pkg::ST_OK ||
                  out_frame_status == cobsd_pkg::ST_TRUNC ||
                  out_frame_status == cobsd_pkg::ST_OVF)
    else $error("invalid frame status");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_byte_valid != out_frame_end)
    else $error("result is neither or both of data and frame end");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> in_ready)
    else $error("input stalled with empty stage");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_vld_r)
    else $error("stages not cleared by reset");

endmodule

`default_nettype wire

// ===== tb/cobs_stream_deframer_unit_tb.sv =====
// Self-checking testbench for cobs_stream_deframer_unit: byte-level COBS
// frames in, decoded bytes and frame-end markers out. Needs cobsd_pkg and the RTL.
`timescale 1ns / 1ps

module cobs_stream_deframer_unit_tb;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned HoldCycles = 400;

  // Tracks the decoder state and the queue of results still due.
  class cobs_decode_tracker;
    logic [cobsd_pkg::ByteW-1:0] limit;
    logic [cobsd_pkg::ByteW-1:0] block_left;
    logic                        prev_full;
    logic                        seen_code;
    logic [cobsd_pkg::ByteW-1:0] enc_count;
    logic                        ovf;
    cobsd_pkg::res_t             due_results[$];
    int                          errors;

    function new();
      limit = cobsd_pkg::MAX_LEN_RST;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      block_left = '0;
      prev_full = 1'b0;
      seen_code = 1'b0;
      enc_count = '0;
      ovf = 1'b0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    task report(input string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // Work out what one accepted line byte produces.
    function void note_byte(input logic [cobsd_pkg::ByteW-1:0] b);
      cobsd_pkg::res_t r;
      bit              hit;
      logic            emit_zero;
      r = '0;
      hit = 1'b0;
      if (b == '0) begin
        if (ovf) begin
          r.frame_end = 1'b1;
          r.frame_status = cobsd_pkg::ST_OVF;
          hit = 1'b1;
        end else if (enc_count != '0) begin
          r.frame_end = 1'b1;
          r.frame_status = (block_left != '0) ? cobsd_pkg::ST_TRUNC : cobsd_pkg::ST_OK;
          hit = 1'b1;
        end
        clear_frame();
      end else if (!ovf) begin
        if (enc_count >= limit) begin
          ovf = 1'b1;
        end else begin
          enc_count = enc_count + 1'b1;
          if (block_left != '0) begin
            block_left = block_left - 1'b1;
            r.decoded_byte = b;
            r.byte_valid = 1'b1;
            hit = 1'b1;
          end else begin
            // a zero stands between blocks unless the last block was full
            emit_zero = seen_code && !prev_full;
            block_left = b - 1'b1;
            prev_full = (b == cobsd_pkg::CODE_FULL);
            seen_code = 1'b1;
            if (emit_zero) begin
              r.byte_valid = 1'b1;
              hit = 1'b1;
            end
          end
        end
      end
      if (hit) due_results.push_back(r);
    endfunction

    task check_result(input cobsd_pkg::res_t got);
      cobsd_pkg::res_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result with nothing due: byte %02h valid %0b end %0b st %0d",
                         got.decoded_byte, got.byte_valid, got.frame_end, got.frame_status));
      end else begin
        want = due_results.pop_front();
        if (got.decoded_byte !== want.decoded_byte)
          report($sformatf("decoded_byte %02h, want %02h", got.decoded_byte, want.decoded_byte));
        if (got.byte_valid !== want.byte_valid)
          report($sformatf("byte_valid %0b, want %0b", got.byte_valid, want.byte_valid));
        if (got.frame_end !== want.frame_end)
          report($sformatf("frame_end %0b, want %0b", got.frame_end, want.frame_end));
        if (got.frame_status !== want.frame_status)
          report($sformatf("frame_status %0d, want %0d", got.frame_status, want.frame_status));
      end
    endtask
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [cobsd_pkg::ByteW-1:0] in_encoded_byte;
  logic                        out_valid;
  logic                        out_ready;
  logic [cobsd_pkg::ByteW-1:0] out_decoded_byte;
  logic                        out_byte_valid;
  logic                        out_frame_end;
  logic [1:0]                  out_frame_status;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [cobsd_pkg::ByteW-1:0] cfg_data;

  cobs_decode_tracker tracker = new();
  int sent_total = 0;
  int phase_sent = 0;

  cobs_stream_deframer_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_encoded_byte  (in_encoded_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_decoded_byte (out_decoded_byte),
    .out_byte_valid   (out_byte_valid),
    .out_frame_end    (out_frame_end),
    .out_frame_status (out_frame_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one line byte and hold it until the transfer.
  task automatic send_byte(input logic [cobsd_pkg::ByteW-1:0] b);
    if (!(sent_total >= 1000 && sent_total < 1250)) begin
      while ($urandom_range(99) < 32) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_encoded_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_byte(b);
    sent_total++;
    phase_sent++;
  endtask

  // Encoded frame of target bytes, cut wherever the count runs out.
  task automatic send_frame(input int target);
    int left;
    int k;
    int code;
    int r;
    left = target;
    while (left > 0) begin
      r = $urandom_range(99);
      if (r < 40) code = $urandom_range(8, 1);
      else if (r < 55) code = cobsd_pkg::CODE_FULL;
      else if (r < 65) code = 1;
      else code = $urandom_range(255, 1);
      send_byte(code[cobsd_pkg::ByteW-1:0]);
      left--;
      for (k = 1; k < code && left > 0; k++) begin
        send_byte(cobsd_pkg::ByteW'($urandom_range(255, 1)));
        left--;
      end
    end
    send_byte('0);
  endtask

  task automatic random_traffic(input int n);
    int r;
    int t;
    int k;
    int cnt;
    phase_sent = 0;
    while (phase_sent < n) begin
      r = $urandom_range(99);
      if (r < 8) begin
        // noise: loose bytes with stray delimiters
        cnt = $urandom_range(6, 1);
        for (k = 0; k < cnt; k++)
          send_byte(($urandom_range(99) < 30) ? cobsd_pkg::ByteW'(0)
                                              : cobsd_pkg::ByteW'($urandom_range(255, 1)));
      end else begin
        r = $urandom_range(99);
        if (r < 5) t = 0;
        else if (r < 65) t = $urandom_range(12, 1);
        else if (r < 85) t = $urandom_range(40, 13);
        else begin
          t = int'(tracker.limit) + int'($urandom_range(3)) - 2;
          if (t < 1) t = 1;
        end
        send_frame(t);
      end
    end
  endtask

  // Drop valid and let every due result and any in-flight byte drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [cobsd_pkg::ByteW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.limit = v;
    cfg_valid <= 1'b0;
  endtask

  // Result side: check each transfer, stall at random, one long hold-off, one stall-free stretch.
  int              got_count = 0;
  int              hold_left = 0;
  bit              hold_done = 1'b0;
  cobsd_pkg::res_t got;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got.decoded_byte = out_decoded_byte;
      got.byte_valid = out_byte_valid;
      got.frame_end = out_frame_end;
      got.frame_status = out_frame_status;
      tracker.check_result(got);
      got_count++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && got_count >= 300) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      out_ready <= 1'b0;
    end else if (got_count >= 900 && got_count < 1150) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 32);
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("cobs_stream_deframer_unit regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_encoded_byte <= '0;
    out_ready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limit: empty frames, empty blocks, zero insertion, truncation
    send_byte(8'h00);
    send_byte(8'h01); send_byte(8'h00);
    send_byte(8'h01); send_byte(8'h01); send_byte(8'h00);
    send_byte(8'h03); send_byte(8'h11); send_byte(8'h22); send_byte(8'h00);
    send_byte(8'h03); send_byte(8'h11); send_byte(8'h00);
    send_byte(8'h02); send_byte(8'hFF); send_byte(8'h01); send_byte(8'h00);
    send_byte(8'h00);
    settle();

    // limit of one: overflow and a full code cut short
    write_limit(8'd1);
    send_byte(8'h02); send_byte(8'h05); send_byte(8'h00);
    send_byte(8'h01); send_byte(8'h00);
    send_byte(8'h05); send_byte(8'h05); send_byte(8'h05); send_byte(8'h00);
    send_byte(8'hFF); send_byte(8'h00);
    random_traffic(80);
    settle();

    write_limit(8'd255);
    random_traffic(450);
    settle();

    write_limit(8'd2);
    random_traffic(100);
    settle();

    write_limit(8'd0);
    random_traffic(40);
    settle();

    write_limit(cobsd_pkg::ByteW'($urandom_range(254, 3)));
    random_traffic(350);
    settle();

    write_limit(cobsd_pkg::MAX_LEN_RST);
    random_traffic(550);
    settle();
    repeat (8) @(posedge clk);

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("cobs_stream_deframer_unit regression: pass");
    end else begin
      $display("cobs_stream_deframer_unit regression: fail");
    end
    $finish;
  end

endmodule
